// ----- design/tsct_pkg.sv -----
// ----------------------------------------------------------------------------
// tsct_pkg: shared types and constants for the Taylor sine/cosine/tangent unit
// Holds operation codes, flag codes, widths and fixed-point helper functions.
// ----------------------------------------------------------------------------
package tsct_pkg;

	localparam int SERIES_TERMS_DEF  = 5;
	localparam int FRACTION_BITS_DEF = 20;
	localparam int ANGLE_W = 24;
	localparam int VALUE_W = 32;
	localparam int OP_W    = 2;
	localparam int FLAGS_W = 2;
	// internal datapath width; series values stay well inside this
	localparam int DATA_W  = 40;
	// multiplier operand magnitude width; folded angles, terms and partial
	// products stay below 2^28 for every supported fraction width
	localparam int MUL_W   = 32;

	localparam logic [OP_W-1:0] OP_SIN    = 2'd0;
	localparam logic [OP_W-1:0] OP_COS    = 2'd1;
	localparam logic [OP_W-1:0] OP_TAN    = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam logic [FLAGS_W-1:0] FLAG_NONE = 2'd0;
	localparam logic [FLAGS_W-1:0] FLAG_SAT  = 2'd1;
	localparam logic [FLAGS_W-1:0] FLAG_ZCOS = 2'd2;

	localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} tsct_ctl_t;

	// pi at fb fractional bits, rounded to nearest
	function automatic logic [DATA_W-1:0] pi_fx(input int fb);
		logic [63:0] t;
		t = (PI_Q61 + (64'd1 << (60 - fb))) >> (61 - fb);
		return t[DATA_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] two_pi_fx(input int fb);
		logic [63:0] t;
		t = (PI_Q61 + (64'd1 << (59 - fb))) >> (60 - fb);
		return t[DATA_W-1:0];
	endfunction

	// round(2^fb / d), constants only
	function automatic logic [DATA_W-1:0] recip_fx(input int fb, input int d);
		logic [63:0] t;
		t = ((64'd1 << fb) + 64'(d / 2)) / 64'(d);
		return t[DATA_W-1:0];
	endfunction

	// signed fixed-point multiply, product rounded half away from zero
	function automatic logic signed [DATA_W-1:0] fx_mul(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b,
		input int fb
	);
		logic [DATA_W-1:0]  ma;
		logic [DATA_W-1:0]  mb;
		logic [2*MUL_W-1:0] p;
		logic               neg;
		neg = a[DATA_W-1] ^ b[DATA_W-1];
		ma  = a[DATA_W-1] ? -a : a;
		mb  = b[DATA_W-1] ? -b : b;
		p   = ((2*MUL_W)'(ma[MUL_W-1:0]) * (2*MUL_W)'(mb[MUL_W-1:0])
			+ ((2*MUL_W)'(1) << (fb - 1))) >> fb;
		return neg ? -p[DATA_W-1:0] : p[DATA_W-1:0];
	endfunction

endpackage

// ----- design/tsct_if.sv -----
// ----------------------------------------------------------------------------
// tsct_in_if / tsct_out_if: valid/ready channels of the unit
// Input carries op and angle; output carries value and flags.
// ----------------------------------------------------------------------------
interface tsct_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [tsct_pkg::OP_W-1:0]            op;
	logic signed [tsct_pkg::ANGLE_W-1:0]  angle;
	modport source (output valid, output op, output angle, input ready);
	modport sink (input valid, input op, input angle, output ready);
endinterface

interface tsct_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [tsct_pkg::VALUE_W-1:0]  value;
	logic [tsct_pkg::FLAGS_W-1:0]         flags;
	modport source (output valid, output value, output flags, input ready);
	modport sink (input valid, input value, input flags, output ready);
endinterface

// ----- design/taylor_sine_cosine_tangent_top.sv -----
// ----------------------------------------------------------------------------
// taylor_sine_cosine_tangent_top: pipelined fixed-point sin/cos/tan
// Fold, series cell chain, restoring divider chain, result register.
// ----------------------------------------------------------------------------
// The unit accepts one word per cycle while not stalled and returns one result word
// per input word, in order. The pipeline holds 3 fold/square stages, 2 stages per
// series term, 1 setup stage, one divider cell per quotient bit (DATA_W +
// FRACTION_BITS of them, 60 by default), and 1 result stage. The whole
// pipeline advances only when the output register is empty or being taken,
// so backpressure stalls every stage together; there is no reset pass.
module taylor_sine_cosine_tangent_top #(
	parameter int SERIES_TERMS  = tsct_pkg::SERIES_TERMS_DEF,
	parameter int FRACTION_BITS = tsct_pkg::FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tsct_in_if.sink     in_ch,
	tsct_out_if.source  out_ch
);
	localparam int DW = tsct_pkg::DATA_W;
	localparam int NW = DW + FRACTION_BITS;
	localparam logic signed [DW-1:0] PI_C  = tsct_pkg::pi_fx(FRACTION_BITS);
	localparam logic signed [DW-1:0] TPI_C = tsct_pkg::two_pi_fx(FRACTION_BITS);
	localparam logic signed [DW-1:0] ONE_C = DW'(1) << FRACTION_BITS;
	localparam logic signed [DW-1:0] VMAX  = DW'(64'sh7FFFFFFF);
	localparam logic signed [DW-1:0] VMIN  = -DW'(64'sh80000000);

	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// fold stage 1 and 2
	logic                 v1_s1, v2_s2, v3_s3;
	tsct_pkg::tsct_ctl_t  c_s1, c_s2, c_s3;
	logic signed [DW-1:0] x_s1, x_s2, x_s3, nx2_s3;
	logic signed [DW-1:0] ax, fx1, fx2, clx;

	assign ax = DW'(in_ch.angle);
	always_comb begin
		fx1 = (ax > PI_C) ? ax - TPI_C : (ax < -PI_C) ? ax + TPI_C : ax;
	end
	always_comb begin
		fx2 = (x_s1 > PI_C) ? x_s1 - TPI_C : (x_s1 < -PI_C) ? x_s1 + TPI_C : x_s1;
		clx = (fx2 > PI_C) ? PI_C : (fx2 < -PI_C) ? -PI_C : fx2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else if (en) begin
			v1_s1 <= in_ch.valid;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1.op <= in_ch.op;
			x_s1    <= fx1;
			c_s2    <= c_s1;
			x_s2    <= clx;
			c_s3    <= c_s2;
			x_s3    <= x_s2;
			nx2_s3  <= -tsct_pkg::fx_mul(x_s2, x_s2, FRACTION_BITS);
		end
	end

	// series chain of term cells
	logic                 cv [SERIES_TERMS+1];
	tsct_pkg::tsct_ctl_t  cc [SERIES_TERMS+1];
	logic signed [DW-1:0] cn [SERIES_TERMS+1];
	logic signed [DW-1:0] st [SERIES_TERMS+1];
	logic signed [DW-1:0] ss [SERIES_TERMS+1];
	logic signed [DW-1:0] ct [SERIES_TERMS+1];
	logic signed [DW-1:0] cs [SERIES_TERMS+1];

	assign cv[0] = v3_s3;
	assign cc[0] = c_s3;
	assign cn[0] = nx2_s3;
	assign st[0] = x_s3;
	assign ss[0] = x_s3;
	assign ct[0] = ONE_C;
	assign cs[0] = ONE_C;

	for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_term
		tsct_term_cell #(.FRACTION_BITS(FRACTION_BITS), .IDX(g + 1)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(cv[g]), .ctl_in(cc[g]), .nx2_in(cn[g]),
			.sterm_in(st[g]), .ssum_in(ss[g]), .cterm_in(ct[g]), .csum_in(cs[g]),
			.vld_out(cv[g+1]), .ctl_out(cc[g+1]), .nx2_out(cn[g+1]),
			.sterm_out(st[g+1]), .ssum_out(ss[g+1]),
			.cterm_out(ct[g+1]), .csum_out(cs[g+1])
		);
	end

	// division setup: side = {sel cos, sel sin, zero cos, neg}
	logic signed [DW-1:0] sv, cvv;
	logic [3:0]           side_d;
	logic [DW-1:0]        ms, mc;
	logic                 dv [NW+1];
	logic [NW-1:0]        dn [NW+1];
	logic [DW:0]          dr [NW+1];
	logic [DW-1:0]        dd [NW+1];
	logic [NW-1:0]        dq [NW+1];
	logic [3:0]           dsd [NW+1];
	logic signed [DW-1:0] res_hold [NW+1];
	logic                 vs_s;
	logic [NW-1:0]        n_s;
	logic [DW-1:0]        d_s;
	logic [3:0]           sd_s;
	logic signed [DW-1:0] r_s;

	assign sv  = ss[SERIES_TERMS];
	assign cvv = cs[SERIES_TERMS];
	assign ms  = sv[DW-1] ? -sv : sv;
	assign mc  = cvv[DW-1] ? -cvv : cvv;
	always_comb begin
		side_d[0] = sv[DW-1] ^ cvv[DW-1];
		side_d[1] = (cvv == '0);
		side_d[2] = (cc[SERIES_TERMS].op == tsct_pkg::OP_SIN);
		side_d[3] = (cc[SERIES_TERMS].op == tsct_pkg::OP_COS);
	end

	// numerator gets +d/2 folded in via dividend (n + d/2)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vs_s <= 1'b0;
		end else if (en) begin
			vs_s <= cv[SERIES_TERMS];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n_s  <= ({{(NW-DW){1'b0}}, ms} << FRACTION_BITS) + NW'(mc >> 1);
			d_s  <= (mc == '0) ? DW'(1) : mc;
			sd_s <= side_d;
			r_s  <= side_d[2] ? sv : cvv;
		end
	end

	assign dv[0]       = vs_s;
	assign dn[0]       = n_s;
	assign dr[0]       = '0;
	assign dd[0]       = d_s;
	assign dq[0]       = '0;
	assign dsd[0]      = sd_s;
	assign res_hold[0] = r_s;

	for (genvar k = 0; k < NW; k++) begin : g_div
		tsct_div_cell #(.NW(NW), .DW(DW)) u_div (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(dv[k]), .num_in(dn[k]), .rem_in(dr[k]), .den_in(dd[k]),
			.quo_in(dq[k]), .side_in(dsd[k]),
			.vld_out(dv[k+1]), .num_out(dn[k+1]), .rem_out(dr[k+1]),
			.den_out(dd[k+1]), .quo_out(dq[k+1]), .side_out(dsd[k+1])
		);
		// carry the sin/cos result alongside the divider
		always_ff @(posedge clk) begin
			if (en) begin
				res_hold[k+1] <= res_hold[k];
			end
		end
	end

	// select and saturate result
	logic [NW-1:0]        q;
	logic [3:0]           sf;
	logic signed [DW-1:0] rv;
	logic signed [tsct_pkg::VALUE_W-1:0] val_d;
	logic [tsct_pkg::FLAGS_W-1:0]        flg_d;

	assign q  = dq[NW];
	assign sf = dsd[NW];
	assign rv = res_hold[NW];
	always_comb begin
		val_d = '0;
		flg_d = tsct_pkg::FLAG_NONE;
		if (sf[2] || sf[3]) begin
			if (rv > VMAX) begin
				val_d = tsct_pkg::VALUE_W'(VMAX);
				flg_d = tsct_pkg::FLAG_SAT;
			end else if (rv < VMIN) begin
				val_d = tsct_pkg::VALUE_W'(VMIN);
				flg_d = tsct_pkg::FLAG_SAT;
			end else begin
				val_d = rv[tsct_pkg::VALUE_W-1:0];
			end
		end else if (sf[1]) begin
			flg_d = tsct_pkg::FLAG_ZCOS;
		end else if (!sf[0] && q > NW'(64'h7FFFFFFF)) begin
			val_d = 32'sh7FFFFFFF;
			flg_d = tsct_pkg::FLAG_SAT;
		end else if (sf[0] && q > NW'(64'h80000000)) begin
			val_d = 32'sh80000000;
			flg_d = tsct_pkg::FLAG_SAT;
		end else begin
			val_d = sf[0] ? -q[tsct_pkg::VALUE_W-1:0] : q[tsct_pkg::VALUE_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (en) begin
			out_ch.valid <= dv[NW];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.value <= val_d;
			out_ch.flags <= flg_d;
		end
	end

	// flags never take the unused code
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.flags <= tsct_pkg::FLAG_ZCOS)
		else $error("bad flags");
	// zero-cosine flag comes with zero value
	a_zc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.flags == tsct_pkg::FLAG_ZCOS) |-> out_ch.value == '0)
		else $error("zero cosine value");
	// stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.value)))
		else $error("output changed under stall");
endmodule

// ----- design/tsct_term_cell.sv -----
// ----------------------------------------------------------------------------
// tsct_term_cell: one series term of sine and cosine
// Two stages: term*(-x2), then *recip and accumulate; passes word onward.
// ----------------------------------------------------------------------------
module tsct_term_cell #(
	parameter int FRACTION_BITS = tsct_pkg::FRACTION_BITS_DEF,
	parameter int IDX = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vld_in,
	input  tsct_pkg::tsct_ctl_t               ctl_in,
	input  logic signed [tsct_pkg::DATA_W-1:0] nx2_in,
	input  logic signed [tsct_pkg::DATA_W-1:0] sterm_in,
	input  logic signed [tsct_pkg::DATA_W-1:0] ssum_in,
	input  logic signed [tsct_pkg::DATA_W-1:0] cterm_in,
	input  logic signed [tsct_pkg::DATA_W-1:0] csum_in,
	output logic                              vld_out,
	output tsct_pkg::tsct_ctl_t               ctl_out,
	output logic signed [tsct_pkg::DATA_W-1:0] nx2_out,
	output logic signed [tsct_pkg::DATA_W-1:0] sterm_out,
	output logic signed [tsct_pkg::DATA_W-1:0] ssum_out,
	output logic signed [tsct_pkg::DATA_W-1:0] cterm_out,
	output logic signed [tsct_pkg::DATA_W-1:0] csum_out
);
	localparam int DW = tsct_pkg::DATA_W;
	localparam logic signed [DW-1:0] S_RECIP =
		tsct_pkg::recip_fx(FRACTION_BITS, (2*IDX) * (2*IDX + 1));
	localparam logic signed [DW-1:0] C_RECIP =
		tsct_pkg::recip_fx(FRACTION_BITS, (2*IDX - 1) * (2*IDX));

	logic                 vld_s1;
	tsct_pkg::tsct_ctl_t  ctl_s1;
	logic signed [DW-1:0] nx2_s1, sp_s1, ssum_s1, cp_s1, csum_s1;
	logic signed [DW-1:0] st_n, ct_n;

	// multiply terms by -x2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= ctl_in;
			nx2_s1  <= nx2_in;
			sp_s1   <= tsct_pkg::fx_mul(sterm_in, nx2_in, FRACTION_BITS);
			cp_s1   <= tsct_pkg::fx_mul(cterm_in, nx2_in, FRACTION_BITS);
			ssum_s1 <= ssum_in;
			csum_s1 <= csum_in;
		end
	end

	// scale by reciprocal and accumulate
	assign st_n = tsct_pkg::fx_mul(sp_s1, S_RECIP, FRACTION_BITS);
	assign ct_n = tsct_pkg::fx_mul(cp_s1, C_RECIP, FRACTION_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_out   <= ctl_s1;
			nx2_out   <= nx2_s1;
			sterm_out <= st_n;
			cterm_out <= ct_n;
			ssum_out  <= ssum_s1 + st_n;
			csum_out  <= csum_s1 + ct_n;
		end
	end
endmodule

// ----- design/tsct_div_cell.sv -----
// ----------------------------------------------------------------------------
// tsct_div_cell: one restoring division step for the tangent quotient
// Each cell settles one quotient bit and hands remainder onward.
// ----------------------------------------------------------------------------
module tsct_div_cell #(
	parameter int NW = 64,
	parameter int DW = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [NW-1:0] num_in,
	input  logic [DW:0]   rem_in,
	input  logic [DW-1:0] den_in,
	input  logic [NW-1:0] quo_in,
	input  logic [3:0]    side_in,
	output logic          vld_out,
	output logic [NW-1:0] num_out,
	output logic [DW:0]   rem_out,
	output logic [DW-1:0] den_out,
	output logic [NW-1:0] quo_out,
	output logic [3:0]    side_out
);
	logic [DW+1:0] sh;
	logic [DW+1:0] diff;
	logic          ge;

	// shift in next numerator bit and trial subtract
	assign sh   = {rem_in, num_in[NW-1]};
	assign diff = sh - {2'b00, den_in};
	assign ge   = !diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			num_out  <= {num_in[NW-2:0], 1'b0};
			rem_out  <= ge ? diff[DW:0] : sh[DW:0];
			den_out  <= den_in;
			quo_out  <= {quo_in[NW-2:0], ge};
			side_out <= side_in;
		end
	end
endmodule
